@@ src/disk_geometry_from_size_assert.svh @@
// assertion macros for the geometry search rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef DISK_GEOMETRY_FROM_SIZE_ASSERT_SVH
`define DISK_GEOMETRY_FROM_SIZE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DGFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DGFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DGFS_ASSERT(lbl, prop, msg)
`define DGFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/dgfs_pkg.sv @@
// types, constants and helpers for the disk geometry search
// no dependencies
package dgfs_pkg;

  localparam int ChoicesPerList = 4;
  localparam int IdxW  = (ChoicesPerList > 1) ? $clog2(ChoicesPerList) : 1;
  localparam int CntW  = 8;
  localparam int ListW = 32;
  localparam int SecW  = 16;
  localparam int HdrW  = 16;
  localparam int SizeW = 31;
  localparam int TrkW  = 32;
  localparam int ExpW  = 41;
  localparam int MulAW = 32;
  localparam int MulBW = 16;
  localparam int ProdW = MulAW + MulBW;
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int DivSteps = ExpW;
  localparam int StepW = $clog2(DivSteps + 1);

  typedef enum logic [2:0] {
    REG_TRACK  = 3'd0,
    REG_HEAD   = 3'd1,
    REG_SECTOR = 3'd2,
    REG_SECB   = 3'd3,
    REG_HDR    = 3'd4,
    REG_ROUND  = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_HS,
    ST_TS,
    ST_EX,
    ST_ADD,
    ST_CMP,
    ST_MOD,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ListW-1:0] track_choices;
    logic [ListW-1:0] head_choices;
    logic [ListW-1:0] sector_choices;
    logic [SecW-1:0]  sector_bytes;
    logic [HdrW-1:0]  header_bytes;
    logic             round_up_tracks;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [ExpW-1:0] dividend;
    logic [TrkW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } mod_rsp_t;

  function automatic logic [CntW-1:0] pick(input logic [ListW-1:0] list,
                                           input logic [IdxW-1:0] idx);
    logic [CntW-1:0] r;
    r = '0;
    for (int i = 0; i < ListW / CntW; i++) begin
      if (int'(idx) == i) begin
        r = list[i*CntW +: CntW];
      end
    end
    return r;
  endfunction

endpackage

@@ src/dgfs_regs.sv @@
// configuration register file with apb-style access
// depends on dgfs_pkg
module dgfs_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dgfs_pkg::AddrW-1:0] paddr,
  input  logic [dgfs_pkg::DataW-1:0] pwdata,
  output logic [dgfs_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output dgfs_pkg::cfg_t            cfg_o
);

  dgfs_pkg::cfg_t cfg_q;
  dgfs_pkg::reg_idx_e idx;
  logic wr;

  assign idx    = dgfs_pkg::reg_idx_e'(paddr[dgfs_pkg::AddrW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_choices   <= '0;
      cfg_q.head_choices    <= '0;
      cfg_q.sector_choices  <= '0;
      cfg_q.sector_bytes    <= dgfs_pkg::SecW'(256);
      cfg_q.header_bytes    <= '0;
      cfg_q.round_up_tracks <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        dgfs_pkg::REG_TRACK:  cfg_q.track_choices   <= pwdata[dgfs_pkg::ListW-1:0];
        dgfs_pkg::REG_HEAD:   cfg_q.head_choices    <= pwdata[dgfs_pkg::ListW-1:0];
        dgfs_pkg::REG_SECTOR: cfg_q.sector_choices  <= pwdata[dgfs_pkg::ListW-1:0];
        dgfs_pkg::REG_SECB:   cfg_q.sector_bytes    <= pwdata[dgfs_pkg::SecW-1:0];
        dgfs_pkg::REG_HDR:    cfg_q.header_bytes    <= pwdata[dgfs_pkg::HdrW-1:0];
        dgfs_pkg::REG_ROUND:  cfg_q.round_up_tracks <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      dgfs_pkg::REG_TRACK:  prdata = dgfs_pkg::DataW'(cfg_q.track_choices);
      dgfs_pkg::REG_HEAD:   prdata = dgfs_pkg::DataW'(cfg_q.head_choices);
      dgfs_pkg::REG_SECTOR: prdata = dgfs_pkg::DataW'(cfg_q.sector_choices);
      dgfs_pkg::REG_SECB:   prdata = dgfs_pkg::DataW'(cfg_q.sector_bytes);
      dgfs_pkg::REG_HDR:    prdata = dgfs_pkg::DataW'(cfg_q.header_bytes);
      dgfs_pkg::REG_ROUND:  prdata = dgfs_pkg::DataW'(cfg_q.round_up_tracks);
      default:              prdata = '0;
    endcase
  end

endmodule

@@ src/dgfs_mod.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on dgfs_pkg
module dgfs_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dgfs_pkg::mod_req_t req_i,
  output dgfs_pkg::mod_rsp_t rsp_o
);

  logic [dgfs_pkg::ExpW-1:0]  dvd_q, dvd_d;
  logic [dgfs_pkg::TrkW-1:0]  dvs_q, dvs_d;
  logic [dgfs_pkg::TrkW-1:0]  rem_q, rem_d;
  logic [dgfs_pkg::StepW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [dgfs_pkg::TrkW:0]    sh;
  logic [dgfs_pkg::TrkW:0]    diff;

  assign sh   = {rem_q, dvd_q[dgfs_pkg::ExpW-1]};
  assign diff = sh - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = dgfs_pkg::StepW'(dgfs_pkg::DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      rem_d = diff[dgfs_pkg::TrkW] ? sh[dgfs_pkg::TrkW-1:0] : diff[dgfs_pkg::TrkW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == dgfs_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

@@ src/dgfs_core.sv @@
// search sequencer with the shared multiplier and result register
// depends on dgfs_pkg, dgfs_mod and the assertion header
`include "disk_geometry_from_size_assert.svh"
module dgfs_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dgfs_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dgfs_pkg::SizeW-1:0]  image_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [dgfs_pkg::CntW-1:0]   track_count_o,
  output logic [dgfs_pkg::CntW-1:0]   head_count_o,
  output logic [dgfs_pkg::CntW-1:0]   sector_count_o
);

  localparam logic [dgfs_pkg::IdxW-1:0] Last = dgfs_pkg::IdxW'(dgfs_pkg::ChoicesPerList - 1);

  dgfs_pkg::state_e state_q, state_d;
  logic [dgfs_pkg::IdxW-1:0]  ti_q, ti_d, hi_q, hi_d, si_q, si_d;
  logic [dgfs_pkg::SizeW-1:0] size_q, size_d;
  logic [dgfs_pkg::ExpW-1:0]  acc_q, acc_d;
  logic [dgfs_pkg::TrkW-1:0]  ts_q, ts_d;
  logic                       hit_q, hit_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [dgfs_pkg::CntW-1:0]  trk_q, trk_d, hd_q, hd_d, sec_q, sec_d;

  logic [dgfs_pkg::CntW-1:0]  t_cur, h_cur, s_cur;
  logic [dgfs_pkg::MulAW-1:0] mul_a;
  logic [dgfs_pkg::MulBW-1:0] mul_b;
  logic [dgfs_pkg::ProdW-1:0] prod;
  logic [dgfs_pkg::ExpW-1:0]  size_ext;
  dgfs_pkg::mod_req_t         mod_req;
  dgfs_pkg::mod_rsp_t         mod_rsp;

  assign t_cur    = dgfs_pkg::pick(cfg_i.track_choices, ti_q);
  assign h_cur    = dgfs_pkg::pick(cfg_i.head_choices, hi_q);
  assign s_cur    = dgfs_pkg::pick(cfg_i.sector_choices, si_q);
  assign size_ext = dgfs_pkg::ExpW'(size_q);
  assign prod     = dgfs_pkg::ProdW'(mul_a) * dgfs_pkg::ProdW'(mul_b);

  dgfs_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      dgfs_pkg::ST_HS: begin
        mul_a = dgfs_pkg::MulAW'(h_cur);
        mul_b = dgfs_pkg::MulBW'(s_cur);
      end
      dgfs_pkg::ST_TS: begin
        mul_a = acc_q[dgfs_pkg::MulAW-1:0];
        mul_b = cfg_i.sector_bytes;
      end
      dgfs_pkg::ST_EX: begin
        mul_a = ts_q;
        mul_b = dgfs_pkg::MulBW'(t_cur);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ti_d        = ti_q;
    hi_d        = hi_q;
    si_d        = si_q;
    size_d      = size_q;
    acc_d       = acc_q;
    ts_d        = ts_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    trk_d       = trk_q;
    hd_d        = hd_q;
    sec_d       = sec_q;
    mod_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      dgfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          size_d  = image_size_i;
          ti_d    = '0;
          hi_d    = '0;
          si_d    = '0;
          hit_d   = 1'b0;
          state_d = dgfs_pkg::ST_CHK;
        end
      end
      dgfs_pkg::ST_CHK: begin
        if (t_cur == '0) begin
          state_d = dgfs_pkg::ST_DONE;
        end else if (h_cur == '0) begin
          hi_d    = Last;
          si_d    = Last;
          state_d = dgfs_pkg::ST_NEXT;
        end else if (s_cur == '0) begin
          si_d    = Last;
          state_d = dgfs_pkg::ST_NEXT;
        end else begin
          state_d = dgfs_pkg::ST_HS;
        end
      end
      dgfs_pkg::ST_HS: begin
        acc_d   = prod[dgfs_pkg::ExpW-1:0];
        state_d = dgfs_pkg::ST_TS;
      end
      dgfs_pkg::ST_TS: begin
        ts_d    = prod[dgfs_pkg::TrkW-1:0];
        state_d = dgfs_pkg::ST_EX;
      end
      dgfs_pkg::ST_EX: begin
        acc_d   = prod[dgfs_pkg::ExpW-1:0];
        state_d = dgfs_pkg::ST_ADD;
      end
      dgfs_pkg::ST_ADD: begin
        acc_d   = acc_q + dgfs_pkg::ExpW'(cfg_i.header_bytes);
        state_d = dgfs_pkg::ST_CMP;
      end
      dgfs_pkg::ST_CMP: begin
        if (acc_q == size_ext) begin
          hit_d   = 1'b1;
          state_d = dgfs_pkg::ST_DONE;
        end else if (cfg_i.round_up_tracks && (acc_q > size_ext) && (ts_q != '0)) begin
          mod_req.start    = 1'b1;
          mod_req.dividend = acc_q - size_ext;
          mod_req.divisor  = ts_q;
          state_d          = dgfs_pkg::ST_MOD;
        end else begin
          state_d = dgfs_pkg::ST_NEXT;
        end
      end
      dgfs_pkg::ST_MOD: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem_zero) begin
            hit_d   = 1'b1;
            state_d = dgfs_pkg::ST_DONE;
          end else begin
            state_d = dgfs_pkg::ST_NEXT;
          end
        end
      end
      dgfs_pkg::ST_NEXT: begin
        state_d = dgfs_pkg::ST_CHK;
        if (si_q != Last) begin
          si_d = si_q + 1'b1;
        end else begin
          si_d = '0;
          if (hi_q != Last) begin
            hi_d = hi_q + 1'b1;
          end else begin
            hi_d = '0;
            if (ti_q != Last) begin
              ti_d = ti_q + 1'b1;
            end else begin
              state_d = dgfs_pkg::ST_DONE;
            end
          end
        end
      end
      dgfs_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          trk_d       = hit_q ? t_cur : '0;
          hd_d        = hit_q ? h_cur : '0;
          sec_d       = hit_q ? s_cur : '0;
          state_d     = dgfs_pkg::ST_IDLE;
        end
      end
      default: state_d = dgfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dgfs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      ti_q        <= '0;
      hi_q        <= '0;
      si_q        <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ti_q        <= ti_d;
      hi_q        <= hi_d;
      si_q        <= si_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    acc_q   <= acc_d;
    ts_q    <= ts_d;
    found_q <= found_d;
    trk_q   <= trk_d;
    hd_q    <= hd_d;
    sec_q   <= sec_d;
  end

  assign in_stall_o     = (state_q != dgfs_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign track_count_o  = trk_q;
  assign head_count_o   = hd_q;
  assign sector_count_o = sec_q;

  `DGFS_ASSERT(a_hit_counts, out_valid_q && found_q |-> (trk_q != '0) && (hd_q != '0) && (sec_q != '0), "found result with a zero count")
  `DGFS_ASSERT(a_miss_counts, out_valid_q && !found_q |-> (trk_q == '0) && (hd_q == '0) && (sec_q == '0), "failed search with nonzero counts")
  `DGFS_ASSERT(a_mod_live, state_q == dgfs_pkg::ST_MOD |-> mod_rsp.busy || mod_rsp.done, "waiting on idle remainder unit")
  `DGFS_ASSERT(a_mod_start, mod_req.start |-> state_q == dgfs_pkg::ST_CMP && !mod_rsp.busy, "remainder unit started out of turn")

endmodule

@@ src/disk_geometry_from_size.sv @@
// disk geometry search from image size: top level
// depends on dgfs_pkg, dgfs_regs, dgfs_core
//
// usage:
//   configure track, head and sector candidate lists (four 8-bit counts each,
//   low byte first, a zero byte ends a list), sector size, header size and
//   round-up mode over the apb-style port; registers at byte address 4*i
//   input channel: image_size_i with in_valid_i / in_stall_o; one transfer
//   starts one search, and in_stall_o stays high until the search has ended
//   output channel: found_o and the three counts with out_valid_o /
//   out_stall_i; exactly one result per input transfer, held in an output
//   register while the receiver stalls; a new input is taken meanwhile
//   sequence: each candidate passes through check, three multiplier passes,
//   header add, compare and advance, and round-up mode may add a run of the
//   41-step bit-serial remainder unit; an empty track list goes from check
//   straight to the result, which is registered before the next input is taken
//   reset: registers return to empty lists, 256-byte sectors, no header,
//   exact match only; no search in flight and no result pending
module disk_geometry_from_size (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dgfs_pkg::AddrW-1:0]  paddr,
  input  logic [dgfs_pkg::DataW-1:0]  pwdata,
  output logic [dgfs_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dgfs_pkg::SizeW-1:0]  image_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [dgfs_pkg::CntW-1:0]   track_count_o,
  output logic [dgfs_pkg::CntW-1:0]   head_count_o,
  output logic [dgfs_pkg::CntW-1:0]   sector_count_o
);

  dgfs_pkg::cfg_t cfg;

  dgfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dgfs_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .image_size_i   (image_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .track_count_o  (track_count_o),
    .head_count_o   (head_count_o),
    .sector_count_o (sector_count_o)
  );

endmodule
